/* hdl/rfd_pkg.sv */
// Package: shared types and constants for the reader frame deframer.
`timescale 1ns / 1ps
package rfd_pkg;

   localparam int MAX_FRAME_BYTES = 128;
   localparam logic [7:0] HEADER_BYTE = 8'hBB;
   localparam logic [7:0] END_BYTE = 8'h7E;
   localparam logic [16:0] FRAME_OVERHEAD = 17'd7;
   localparam int CAP_DEPTH = 17;
   localparam logic [7:0] CAP_FIRST = 8'd5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NOTICE_FRAME = 8'h02;
   localparam logic [7:0] RESPONSE_FRAME = 8'h01;
   localparam logic [7:0] CMD_TAG = 8'h22;
   localparam logic [7:0] CMD_POWER = 8'hB7;
   localparam logic [7:0] CMD_POWER_ACK = 8'hB6;
   localparam logic [7:0] CMD_REGION = 8'h08;
   localparam logic [7:0] CMD_ERROR = 8'hFF;
   localparam logic [7:0] CMD_MODEM = 8'hF1;
   localparam logic [7:0] CMD_MODEM_ACK = 8'hF0;
   localparam logic [7:0] CMD_HOP_ACK = 8'hAD;

   localparam logic [1:0] ST_GOOD = 2'd0;
   localparam logic [1:0] ST_CHECKSUM = 2'd1;
   localparam logic [1:0] ST_BAD_END = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   localparam logic [3:0] KIND_TAG = 4'd0;
   localparam logic [3:0] KIND_POWER = 4'd1;
   localparam logic [3:0] KIND_POWER_ACK = 4'd2;
   localparam logic [3:0] KIND_REGION = 4'd3;
   localparam logic [3:0] KIND_ERROR = 4'd4;
   localparam logic [3:0] KIND_MODEM = 4'd5;
   localparam logic [3:0] KIND_MODEM_ACK = 4'd6;
   localparam logic [3:0] KIND_HOP_ACK = 4'd7;
   localparam logic [3:0] KIND_OTHER_RSP = 4'd8;
   localparam logic [3:0] KIND_OTHER_TYPE = 4'd9;

   typedef enum logic [2:0] {
      PH_HUNT, PH_TYPE, PH_CMD, PH_LENHI, PH_LENLO, PH_BODY
   } phase_type;

   // Finished frame handed from the parser to the decoder
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] ftype;
      logic [7:0] command;
      logic [6:0] plen;
      logic [CAP_DEPTH*8-1:0] cap;   // frame byte 5 in bits [7:0]
   } frame_type_rec_type;

endpackage

/* hdl/rfd_parser.sv */
// Front end: header hunt, field capture, checksum and end-marker checks.
`timescale 1ns / 1ps
module rfd_parser (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [7:0] in_byte,
   output logic in_ready,
   output logic frm_valid,
   output rfd_pkg::frame_type_rec_type frm_data,
   input  logic frm_ready
);
   import rfd_pkg::*;

   phase_type phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic [16:0] size_ff, size_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] ftype_ff, ftype_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] chk_ff, chk_in;
   logic [7:0] cap_ff [CAP_DEPTH];
   logic emit;
   logic [1:0] emit_status;
   logic [16:0] emit_plen;
   logic [16:0] size_sum;
   logic [8:0] cap_idx;
   logic accept;

   assign in_ready = frm_ready;
   assign accept = in_valid && in_ready;
   assign size_sum = {size_ff[16:8], in_byte} + FRAME_OVERHEAD;
   assign cap_idx = {1'b0, pos_ff} - {1'b0, CAP_FIRST};

   // Next state
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      size_in = size_ff;
      sum_in = sum_ff;
      ftype_in = ftype_ff;
      cmd_in = cmd_ff;
      chk_in = chk_ff;
      case (phase_ff)
         PH_TYPE: begin
            ftype_in = in_byte; sum_in = sum_ff + in_byte; phase_in = PH_CMD;
         end
         PH_CMD: begin
            cmd_in = in_byte; sum_in = sum_ff + in_byte; phase_in = PH_LENHI;
         end
         PH_LENHI: begin
            size_in = {1'b0, in_byte, 8'd0}; sum_in = sum_ff + in_byte;
            phase_in = PH_LENLO;
         end
         PH_LENLO: begin
            sum_in = sum_ff + in_byte;
            if (size_sum > 17'(MAX_FRAME_BYTES)) begin
               size_in = {size_ff[16:8], in_byte};
               phase_in = PH_HUNT;
            end else begin
               size_in = size_sum; pos_in = CAP_FIRST; phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            if ({9'd0, pos_ff} + 17'd2 < size_ff) begin
               sum_in = sum_ff + in_byte; pos_in = pos_ff + 8'd1;
            end else if ({9'd0, pos_ff} + 17'd2 == size_ff) begin
               chk_in = in_byte; pos_in = pos_ff + 8'd1;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         default: begin
            if (in_byte == HEADER_BYTE) begin
               sum_in = 8'd0; chk_in = 8'd0; phase_in = PH_TYPE;
            end
         end
      endcase
   end

   // Result outputs
   always_comb begin
      emit = 1'b0;
      emit_status = ST_GOOD;
      emit_plen = size_ff - FRAME_OVERHEAD;
      case (phase_ff)
         PH_LENLO: begin
            if (size_sum > 17'(MAX_FRAME_BYTES)) begin
               emit = 1'b1; emit_status = ST_TOO_LONG;
               emit_plen = {size_ff[16:8], in_byte};
            end
         end
         PH_BODY: begin
            if ({9'd0, pos_ff} + 17'd2 > size_ff) begin
               emit = 1'b1;
               if (in_byte != END_BYTE) emit_status = ST_BAD_END;
               else if (chk_ff != sum_ff) emit_status = ST_CHECKSUM;
               else emit_status = ST_GOOD;
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff <= 8'd0;
         size_ff <= 17'd0;
         sum_ff <= 8'd0;
         ftype_ff <= 8'd0;
         cmd_ff <= 8'd0;
         chk_ff <= 8'd0;
         for (int i = 0; i < CAP_DEPTH; i++) cap_ff[i] <= 8'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         size_ff <= size_in;
         sum_ff <= sum_in;
         ftype_ff <= ftype_in;
         cmd_ff <= cmd_in;
         chk_ff <= chk_in;
         if (phase_ff == PH_HUNT && in_byte == HEADER_BYTE) begin
            for (int i = 0; i < CAP_DEPTH; i++) cap_ff[i] <= 8'd0;
         end else if (phase_ff == PH_BODY && {9'd0, pos_ff} + 17'd2 < size_ff
                      && cap_idx < 9'(CAP_DEPTH)) begin
            cap_ff[cap_idx[4:0]] <= in_byte;
         end
      end
   end

   // Frame record toward the queue
   always_comb begin
      frm_valid = accept && emit;
      frm_data.status = emit_status;
      frm_data.ftype = ftype_ff;
      frm_data.command = cmd_ff;
      frm_data.plen = (emit_plen > 17'd127) ? 7'd127 : emit_plen[6:0];
      for (int i = 0; i < CAP_DEPTH; i++) frm_data.cap[i*8 +: 8] = cap_ff[i];
   end

   property p_no_body_on_reset;
      @(posedge clock) reset |=> phase_ff == PH_HUNT;
   endproperty
   a_reset: assert property (p_no_body_on_reset) else $error("phase not cleared");
   a_hunt_after_emit: assert property (@(posedge clock) disable iff (reset)
      frm_valid |=> phase_ff == PH_HUNT) else $error("no hunt after result");
   a_size_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> size_ff <= 17'(MAX_FRAME_BYTES))
      else $error("frame size over limit");
endmodule

/* hdl/rfd_queue.sv */
// Short frame queue between parser and decoder.
`timescale 1ns / 1ps
module rfd_queue (
   input  logic clock,
   input  logic reset,
   input  logic wr_valid,
   input  rfd_pkg::frame_type_rec_type wr_data,
   output logic wr_ready,
   output logic rd_valid,
   output rfd_pkg::frame_type_rec_type rd_data,
   input  logic rd_ready
);
   import rfd_pkg::*;

   frame_type_rec_type mem_ff [QUEUE_DEPTH];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic push, pop;

   assign wr_ready = cnt_ff != 2'(QUEUE_DEPTH);
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data = mem_ff[rp_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
   a_pushpop: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop when empty");
endmodule

/* hdl/rfd_decoder.sv */
// Back end: decodes a frame record into result fields, registered output.
`timescale 1ns / 1ps
module rfd_decoder (
   input  logic clock,
   input  logic reset,
   input  logic frm_valid,
   input  rfd_pkg::frame_type_rec_type frm_data,
   output logic frm_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic [1:0] frame_status,
   output logic [3:0] frame_kind,
   output logic [7:0] command_code,
   output logic [6:0] payload_length,
   output logic signed [8:0] signal_strength,
   output logic [15:0] protocol_control,
   output logic [63:0] epc_upper,
   output logic [31:0] epc_lower,
   output logic [15:0] tag_crc,
   output logic [15:0] word_value,
   output logic [7:0] first_byte,
   output logic [7:0] second_byte
);
   import rfd_pkg::*;

   logic valid_ff;
   logic load;
   logic [3:0] kind_in;
   logic signed [8:0] ss_in;
   logic [15:0] pc_in, crc_in, wv_in;
   logic [63:0] eu_in;
   logic [31:0] el_in;
   logic [7:0] fb_in, sb_in;
   logic [7:0] cb [CAP_DEPTH];

   assign frm_ready = !valid_ff || out_ready;
   assign load = frm_valid && frm_ready;
   assign out_valid = valid_ff;

   always_comb begin
      for (int i = 0; i < CAP_DEPTH; i++) cb[i] = frm_data.cap[i*8 +: 8];
      kind_in = KIND_TAG;
      ss_in = '0; pc_in = '0; eu_in = '0; el_in = '0; crc_in = '0;
      wv_in = '0; fb_in = '0; sb_in = '0;
      if (frm_data.status == ST_GOOD) begin
         if (frm_data.ftype == NOTICE_FRAME && frm_data.command == CMD_TAG) begin
            kind_in = KIND_TAG;
            ss_in = $signed({1'b0, cb[0]}) - 9'sd255;
            pc_in = {cb[1], cb[2]};
            eu_in = {cb[3], cb[4], cb[5], cb[6], cb[7], cb[8], cb[9], cb[10]};
            el_in = {cb[11], cb[12], cb[13], cb[14]};
            crc_in = {cb[15], cb[16]};
         end else if (frm_data.ftype == RESPONSE_FRAME) begin
            case (frm_data.command)
               CMD_POWER: begin kind_in = KIND_POWER; wv_in = {cb[0], cb[1]}; end
               CMD_POWER_ACK: kind_in = KIND_POWER_ACK;
               CMD_REGION: begin kind_in = KIND_REGION; fb_in = cb[0]; end
               CMD_ERROR: begin kind_in = KIND_ERROR; fb_in = cb[0]; end
               CMD_MODEM: begin
                  kind_in = KIND_MODEM; fb_in = cb[0]; sb_in = cb[1];
                  wv_in = {cb[2], cb[3]};
               end
               CMD_MODEM_ACK: kind_in = KIND_MODEM_ACK;
               CMD_HOP_ACK: kind_in = KIND_HOP_ACK;
               default: kind_in = KIND_OTHER_RSP;
            endcase
         end else begin
            kind_in = KIND_OTHER_TYPE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (frm_ready) valid_ff <= frm_valid;
      if (load) begin
         frame_status <= frm_data.status;
         frame_kind <= kind_in;
         command_code <= frm_data.command;
         payload_length <= frm_data.plen;
         signal_strength <= ss_in;
         protocol_control <= pc_in;
         epc_upper <= eu_in;
         epc_lower <= el_in;
         tag_crc <= crc_in;
         word_value <= wv_in;
         first_byte <= fb_in;
         second_byte <= sb_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(frame_status))
      else $error("result dropped");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && frame_status != ST_GOOD |-> frame_kind == KIND_TAG)
      else $error("kind on bad frame");
   a_load: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid) else $error("load lost");
endmodule

/* hdl/reader_frame_deframer.sv */
// Top level: reader frame deframer.
`timescale 1ns / 1ps
// Accepts one received byte per cycle (req_rx_byte) and emits one result per
// frame on the rsp_ channel. The parser takes a byte every cycle while the
// two-entry frame queue has room; a finished frame passes the queue and is
// decoded into the output register. Only a stalled rsp_ side with a full
// queue holds back req_ready; bytes outside a frame give no result.
module reader_frame_deframer (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_frame_status,
   output logic [3:0] rsp_frame_kind,
   output logic [7:0] rsp_command_code,
   output logic [6:0] rsp_payload_length,
   output logic signed [8:0] rsp_signal_strength,
   output logic [15:0] rsp_protocol_control,
   output logic [63:0] rsp_epc_upper,
   output logic [31:0] rsp_epc_lower,
   output logic [15:0] rsp_tag_crc,
   output logic [15:0] rsp_word_value,
   output logic [7:0] rsp_first_byte,
   output logic [7:0] rsp_second_byte
);
   import rfd_pkg::*;

   logic f_valid, f_ready, q_valid, q_ready;
   frame_type_rec_type f_data, q_data;

   rfd_parser u_parser (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_byte(req_rx_byte),
      .in_ready(req_ready), .frm_valid(f_valid), .frm_data(f_data),
      .frm_ready(f_ready));

   rfd_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(f_valid), .wr_data(f_data),
      .wr_ready(f_ready), .rd_valid(q_valid), .rd_data(q_data),
      .rd_ready(q_ready));

   rfd_decoder u_decoder (
      .clock(clock), .reset(reset), .frm_valid(q_valid), .frm_data(q_data),
      .frm_ready(q_ready), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .frame_status(rsp_frame_status), .frame_kind(rsp_frame_kind),
      .command_code(rsp_command_code), .payload_length(rsp_payload_length),
      .signal_strength(rsp_signal_strength),
      .protocol_control(rsp_protocol_control), .epc_upper(rsp_epc_upper),
      .epc_lower(rsp_epc_lower), .tag_crc(rsp_tag_crc),
      .word_value(rsp_word_value), .first_byte(rsp_first_byte),
      .second_byte(rsp_second_byte));
endmodule

/* verif/rfd_checker.sv */
// Checker for the reader frame deframer: frame predictor and result scoreboard.
`timescale 1ns / 1ps
module rfd_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [1:0] rsp_frame_status,
   input  logic [3:0] rsp_frame_kind,
   input  logic [7:0] rsp_command_code,
   input  logic [6:0] rsp_payload_length,
   input  logic signed [8:0] rsp_signal_strength,
   input  logic [15:0] rsp_protocol_control,
   input  logic [63:0] rsp_epc_upper,
   input  logic [31:0] rsp_epc_lower,
   input  logic [15:0] rsp_tag_crc,
   input  logic [15:0] rsp_word_value,
   input  logic [7:0] rsp_first_byte,
   input  logic [7:0] rsp_second_byte,
   output int fail_count,
   output int pending_count
);
   import rfd_pkg::*;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] kind;
      logic [7:0] command;
      logic [6:0] plen;
      logic signed [8:0] rssi;
      logic [15:0] pc;
      logic [63:0] epc_hi;
      logic [31:0] epc_lo;
      logic [15:0] crc;
      logic [15:0] word;
      logic [7:0] b5;
      logic [7:0] b6;
   } frame_result_type;

   frame_result_type expected_frames[$];

   // predictor state
   phase_type ph;
   logic [7:0] pos;
   logic [16:0] fsize;
   logic [7:0] csum;
   logic [7:0] ftype;
   logic [7:0] fcmd;
   logic [7:0] body[CAP_DEPTH];
   logic [7:0] rx_check;

   function automatic logic [7:0] body_at(input int n);
      return body[n - 5];
   endfunction

   function automatic frame_result_type decode_frame(input logic [1:0] st,
                                                     input logic [16:0] plen);
      frame_result_type r;
      r = '0;
      r.status = st;
      r.command = fcmd;
      r.plen = plen > 127 ? 7'd127 : plen[6:0];
      if (st != ST_GOOD) return r;
      if (ftype == NOTICE_FRAME && fcmd == CMD_TAG) begin
         r.kind = KIND_TAG;
         r.rssi = $signed({1'b0, body_at(5)}) - 9'sd255;
         r.pc = {body_at(6), body_at(7)};
         for (int i = 8; i < 16; i++) r.epc_hi = {r.epc_hi[55:0], body_at(i)};
         for (int i = 16; i < 20; i++) r.epc_lo = {r.epc_lo[23:0], body_at(i)};
         r.crc = {body_at(20), body_at(21)};
      end else if (ftype == RESPONSE_FRAME) begin
         case (fcmd)
            CMD_POWER: begin
               r.kind = KIND_POWER;
               r.word = {body_at(5), body_at(6)};
            end
            CMD_POWER_ACK: r.kind = KIND_POWER_ACK;
            CMD_REGION: begin
               r.kind = KIND_REGION;
               r.b5 = body_at(5);
            end
            CMD_ERROR: begin
               r.kind = KIND_ERROR;
               r.b5 = body_at(5);
            end
            CMD_MODEM: begin
               r.kind = KIND_MODEM;
               r.b5 = body_at(5);
               r.b6 = body_at(6);
               r.word = {body_at(7), body_at(8)};
            end
            CMD_MODEM_ACK: r.kind = KIND_MODEM_ACK;
            CMD_HOP_ACK: r.kind = KIND_HOP_ACK;
            default: r.kind = KIND_OTHER_RSP;
         endcase
      end else begin
         r.kind = KIND_OTHER_TYPE;
      end
      return r;
   endfunction

   // advance the predictor on each accepted byte
   task automatic take_byte(input logic [7:0] b);
      logic [16:0] total;
      case (ph)
         PH_TYPE: begin
            ftype = b; csum += b; ph = PH_CMD;
         end
         PH_CMD: begin
            fcmd = b; csum += b; ph = PH_LENHI;
         end
         PH_LENHI: begin
            fsize = {1'b0, b, 8'h00}; csum += b; ph = PH_LENLO;
         end
         PH_LENLO: begin
            fsize[7:0] = b;
            csum += b;
            total = fsize + FRAME_OVERHEAD;
            if (total > MAX_FRAME_BYTES) begin
               expected_frames.push_back(decode_frame(ST_TOO_LONG, fsize));
               ph = PH_HUNT;
            end else begin
               fsize = total; pos = CAP_FIRST; ph = PH_BODY;
            end
         end
         PH_BODY: begin
            if (pos + 2 < fsize) begin
               if (pos - CAP_FIRST < CAP_DEPTH) body[pos - CAP_FIRST] = b;
               csum += b;
               pos++;
            end else if (pos + 2 == fsize) begin
               rx_check = b;
               pos++;
            end else begin
               // bad end marker outranks a checksum mismatch
               if (b != END_BYTE)
                  expected_frames.push_back(decode_frame(ST_BAD_END, fsize - FRAME_OVERHEAD));
               else if (rx_check != csum)
                  expected_frames.push_back(decode_frame(ST_CHECKSUM, fsize - FRAME_OVERHEAD));
               else
                  expected_frames.push_back(decode_frame(ST_GOOD, fsize - FRAME_OVERHEAD));
               ph = PH_HUNT;
            end
         end
         default: begin
            if (b == HEADER_BYTE) begin
               foreach (body[i]) body[i] = '0;
               csum = '0; rx_check = '0; pos = 1; ph = PH_TYPE;
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type e;
      if (reset) begin
         ph = PH_HUNT; pos = 0; fsize = 0; csum = 0; ftype = 0; fcmd = 0; rx_check = 0;
         foreach (body[i]) body[i] = '0;
         expected_frames.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) take_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("result transfer with no frame expected");
               fail_count++;
            end else begin
               e = expected_frames.pop_front();
               compare_field("frame_status", e.status, rsp_frame_status);
               compare_field("frame_kind", e.kind, rsp_frame_kind);
               compare_field("command_code", e.command, rsp_command_code);
               compare_field("payload_length", e.plen, rsp_payload_length);
               compare_field("signal_strength", e.rssi, rsp_signal_strength);
               compare_field("protocol_control", e.pc, rsp_protocol_control);
               compare_field("epc_upper", e.epc_hi, rsp_epc_upper);
               compare_field("epc_lower", e.epc_lo, rsp_epc_lower);
               compare_field("tag_crc", e.crc, rsp_tag_crc);
               compare_field("word_value", e.word, rsp_word_value);
               compare_field("first_byte", e.b5, rsp_first_byte);
               compare_field("second_byte", e.b6, rsp_second_byte);
            end
         end
      end
      pending_count = expected_frames.size();
   end

endmodule

/* verif/tb_top.sv */
// Testbench top: byte stimulus, back-pressure and verdict for the deframer.
`timescale 1ns / 1ps
module tb_top;
   import rfd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_frame_status;
   logic [3:0] rsp_frame_kind;
   logic [7:0] rsp_command_code;
   logic [6:0] rsp_payload_length;
   logic signed [8:0] rsp_signal_strength;
   logic [15:0] rsp_protocol_control;
   logic [63:0] rsp_epc_upper;
   logic [31:0] rsp_epc_lower;
   logic [15:0] rsp_tag_crc;
   logic [15:0] rsp_word_value;
   logic [7:0] rsp_first_byte;
   logic [7:0] rsp_second_byte;
   int fail_count;
   int pending_count;

   int send_idle_pct;
   int recv_idle_pct;

   always #1 clock = ~clock;

   reader_frame_deframer dut (.*);
   rfd_checker checker_i (.*);

   // receiver stall pattern
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one byte transfer, with a random gap ahead of it; valid stays up after
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // whole frame; checksum fixed up unless corrupted, end marker as given
   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] cmd,
                             input logic [15:0] plen, input bit bad_sum,
                             input logic [7:0] end_b, input bit rand_body);
      logic [7:0] s;
      logic [7:0] b;
      s = ftype + cmd + plen[15:8] + plen[7:0];
      send_byte(HEADER_BYTE);
      send_byte(ftype);
      send_byte(cmd);
      send_byte(plen[15:8]);
      send_byte(plen[7:0]);
      if (plen + 7 > MAX_FRAME_BYTES) return;
      for (int i = 0; i < plen; i++) begin
         b = rand_body ? 8'($urandom) : 8'((i * 37 + 5) ^ {8{i[0]}});
         s += b;
         send_byte(b);
      end
      send_byte(bad_sum ? s ^ 8'($urandom_range(255, 1)) : s);
      send_byte(end_b);
   endtask

   task automatic random_frame();
      logic [7:0] t;
      logic [7:0] c;
      logic [15:0] l;
      int r;
      logic [7:0] cmds[9] = '{CMD_TAG, CMD_POWER, CMD_POWER_ACK, CMD_REGION, CMD_ERROR,
                             CMD_MODEM, CMD_MODEM_ACK, CMD_HOP_ACK, 8'h00};
      r = $urandom_range(99);
      t = r < 45 ? RESPONSE_FRAME : r < 85 ? NOTICE_FRAME : 8'($urandom);
      c = $urandom_range(9) == 0 ? 8'($urandom) : cmds[$urandom_range(8)];
      r = $urandom_range(99);
      if (r < 5) l = 16'($urandom);
      else if (r < 10) l = 16'($urandom_range(121, 122));
      else if (r < 15) l = 16'($urandom_range(121, 0));
      else l = 16'($urandom_range(24, 0));
      // occasional line noise between frames
      if ($urandom_range(9) == 0) send_byte(8'($urandom));
      send_frame(t, c, l, $urandom_range(9) == 0,
                 $urandom_range(11) == 0 ? 8'($urandom) : END_BYTE, 1);
   endtask

   initial begin
      send_idle_pct = 7;
      recv_idle_pct = 83;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed frames: each kind, error cases, extreme lengths
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(NOTICE_FRAME, CMD_TAG, 16'd22, 0, END_BYTE, 0);
      send_frame(NOTICE_FRAME, CMD_TAG, 16'd3, 0, END_BYTE, 0);
      send_frame(RESPONSE_FRAME, CMD_POWER, 16'd2, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_POWER_ACK, 16'd0, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_REGION, 16'd1, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_ERROR, 16'd1, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_MODEM, 16'd4, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_MODEM_ACK, 16'd1, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_HOP_ACK, 16'd0, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, 8'h55, 16'd2, 0, END_BYTE, 1);
      send_frame(8'hFF, 8'h00, 16'd121, 0, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_POWER, 16'd2, 1, END_BYTE, 1);
      send_frame(RESPONSE_FRAME, CMD_POWER, 16'd2, 0, 8'h81, 1);
      send_frame(RESPONSE_FRAME, CMD_POWER, 16'd2, 1, 8'h00, 1);
      send_frame(NOTICE_FRAME, CMD_TAG, 16'd122, 0, END_BYTE, 1);
      send_frame(NOTICE_FRAME, CMD_TAG, 16'hFFFF, 0, END_BYTE, 1);

      // hold off until every expected result is out
      req_valid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin send_idle_pct = 83; recv_idle_pct = 7; end
         if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
         for (int k = 0; k < 9; k++) random_frame();
      end
      // full-rate stretch of raw noise
      for (int k = 0; k < 60; k++) send_byte(8'($urandom));
      req_valid <= 1'b0;

      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
